[hw/rtl/sqvu_pkg.sv]
// Shared types, constants and the root table for the quantile update unit.
// No dependencies.
`default_nettype none
package sqvu_pkg;
  localparam int VECTOR_LENGTH_DEF = 1024;
  localparam int IDX_W = 10;
  localparam int SMP_W = 32;
  localparam int CFG_W = 16;
  localparam int STEP_W = 24;
  localparam int CNT_W = 16;
  localparam int TDATA_W = 48;

  localparam logic [CNT_W-1:0] COUNT_MAX = 16'hFFFF;
  localparam logic [20:0] GAMMA_BASE = 21'd6554;
  localparam logic [15:0] GAMMA_SPAN = 16'd58982;
  localparam logic [15:0] ALPHA_RST = 16'd32768;
  localparam logic [15:0] MAXIT_RST = 16'd1000;

  typedef enum logic {
    REG_ALPHA = 1'b0,
    REG_MAXIT = 1'b1
  } reg_idx_t;

  typedef logic [31:0] root_arr_t [16];

  typedef struct packed {
    logic signed [SMP_W-1:0] sample;
    logic [IDX_W-1:0]        idx;
    logic                    last;
    logic                    in_range;
  } item_t;

  typedef struct packed {
    logic        start;
    logic [15:0] n;
    logic [15:0] nmax;
  } step_req_t;

  typedef struct packed {
    logic              done;
    logic [STEP_W-1:0] step;
  } step_rsp_t;

  function automatic logic [63:0] isqrt64(input logic [63:0] v);
    logic [63:0] rem;
    logic [63:0] res;
    logic [63:0] b;
    rem = v;
    res = '0;
    b = 64'd1 << 62;
    for (int i = 0; i < 32; i++) begin
      if (rem >= res + b) begin
        rem = rem - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  // root j = 2^(-2^-j) in Q30, j = 1..16
  function automatic root_arr_t root_init();
    root_arr_t t;
    logic [63:0] c;
    c = isqrt64(64'd1 << 59);
    for (int j = 0; j < 16; j++) begin
      t[j] = c[31:0];
      c = isqrt64(c << 30);
    end
    return t;
  endfunction

  localparam root_arr_t ROOTS = root_init();
endpackage
`default_nettype wire

[hw/rtl/sqvu_ram.sv]
// Generic single-port RAM with registered read.
// No dependencies.
`default_nettype none
module sqvu_ram #(
  parameter int W = 32,
  parameter int D = 1024,
  localparam int AW = (D > 1) ? $clog2(D) : 1
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] addr,
  input  wire logic [W-1:0]  wdata,
  output logic [W-1:0]       rdata
);
  logic [W-1:0] mem [D];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule
`default_nettype wire

[hw/rtl/sqvu_front.sv]
// Input side: accepts beats, classifies them and queues them for the back end.
// Depends on sqvu_pkg.
`default_nettype none
module sqvu_front import sqvu_pkg::*; #(
  parameter int VECTOR_LENGTH = VECTOR_LENGTH_DEF
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                s_tvalid,
  output logic                     s_tready,
  input  wire logic [TDATA_W-1:0]  s_tdata,
  input  wire logic                s_tlast,
  output logic                     q_valid,
  output item_t                    q_item,
  input  wire logic                q_pop
);
  item_t       slots [2];
  logic        wr_ptr;
  logic        rd_ptr;
  logic [1:0]  fill;
  logic        push;
  item_t       incoming;

  assign s_tready = (fill != 2'd2);
  assign push = s_tvalid && s_tready;
  assign q_valid = (fill != 2'd0);
  assign q_item = slots[rd_ptr];

  always_comb begin
    incoming.sample = s_tdata[SMP_W-1:0];
    incoming.idx = s_tdata[SMP_W+IDX_W-1:SMP_W];
    incoming.last = s_tlast;
    incoming.in_range = (32'(s_tdata[SMP_W+IDX_W-1:SMP_W]) < 32'(VECTOR_LENGTH));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (q_pop) begin
        rd_ptr <= ~rd_ptr;
      end
      fill <= fill + 2'(push) - 2'(q_pop);
    end
    if (push) begin
      slots[wr_ptr] <= incoming;
    end
  end
endmodule
`default_nettype wire

[hw/rtl/sqvu_step.sv]
// Per-vector step unit: gamma by long division, log2 by squaring, then
// 2^-E by a product of stored roots. Depends on sqvu_pkg.
`default_nettype none
module sqvu_step import sqvu_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire step_req_t req,
  output step_rsp_t      rsp
);
  typedef enum logic [2:0] {
    S_IDLE, S_MUL, S_DIV, S_LOG, S_EXP, S_POW, S_FIN
  } state_t;

  state_t      state;
  logic [15:0] n_r;
  logic [15:0] d_r;
  logic [31:0] num;
  logic [15:0] rem;
  logic [31:0] quo;
  logic [4:0]  cnt;
  logic [3:0]  e_r;
  logic [30:0] x;
  logic [15:0] frac;
  logic [25:0] eq;
  logic [30:0] r;

  logic [3:0]  e_c;
  logic [46:0] xw;
  logic [16:0] trial;
  logic        ge;
  logic [61:0] sq;
  logic [31:0] sqs;
  logic [20:0] gsat;
  logic [41:0] gl;
  logic [61:0] rp;
  logic [9:0]  k;
  logic [4:0]  sh;
  logic [31:0] rnd;
  logic [15:0] nmax_c;

  always_comb begin
    e_c = '0;
    for (int i = 0; i < 16; i++) begin
      if (n_r[i]) begin
        e_c = 4'(i);
      end
    end
    xw = (47'(n_r) << 30) >> e_c;
    trial = {rem, num[31]};
    ge = (trial >= {1'b0, d_r});
    sq = 62'(x) * 62'(x);
    sqs = sq[61:30];
    gsat = (quo > 32'(21'h1FFFFF - GAMMA_BASE)) ? 21'h1FFFFF : 21'(quo) + GAMMA_BASE;
    gl = 42'(gsat) * 42'({e_r, frac}) + 42'd32768;
    rp = 62'(r) * 62'(ROOTS[cnt[3:0]]);
    k = eq[25:16];
    sh = k[4:0] + 5'd6;
    rnd = (32'(r) + (32'd1 << (sh - 5'd1))) >> sh;
    nmax_c = (req.nmax < 16'd2) ? 16'd2 : req.nmax;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      rsp.done <= 1'b0;
      rsp.step <= '0;
    end else begin
      rsp.done <= (state == S_FIN);
      unique case (state)
        S_IDLE: begin
          if (req.start) begin
            n_r <= req.n;
            d_r <= nmax_c - 16'd1;
            state <= S_MUL;
          end
        end
        S_MUL: begin
          num <= 32'(GAMMA_SPAN) * 32'(n_r - 16'd1) + 32'(d_r >> 1);
          rem <= '0;
          quo <= '0;
          cnt <= '0;
          state <= S_DIV;
        end
        S_DIV: begin
          rem <= ge ? 16'(trial - {1'b0, d_r}) : trial[15:0];
          quo <= {quo[30:0], ge};
          num <= num << 1;
          if (cnt == 5'd31) begin
            e_r <= e_c;
            x <= xw[30:0];
            frac <= '0;
            cnt <= '0;
            state <= S_LOG;
          end else begin
            cnt <= cnt + 5'd1;
          end
        end
        S_LOG: begin
          x <= sqs[31] ? sqs[31:1] : sqs[30:0];
          frac <= {frac[14:0], sqs[31]};
          cnt <= cnt + 5'd1;
          if (cnt == 5'd15) begin
            state <= S_EXP;
          end
        end
        S_EXP: begin
          eq <= gl[41:16];
          r <= 31'h40000000;
          cnt <= '0;
          state <= S_POW;
        end
        S_POW: begin
          if (eq[4'd15 - cnt[3:0]]) begin
            r <= rp[60:30];
          end
          cnt <= cnt + 5'd1;
          if (cnt == 5'd15) begin
            state <= S_FIN;
          end
        end
        S_FIN: begin
          if (k > 10'd24) begin
            rsp.step <= '0;
          end else if (rnd > 32'hFFFFFF) begin
            rsp.step <= 24'hFFFFFF;
          end else begin
            rsp.step <= rnd[23:0];
          end
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

[hw/rtl/sqvu_back.sv]
// Back end: reads the stored estimate, applies the update, writes it back and
// holds the result beat; runs the step unit at each vector end.
// Depends on sqvu_pkg, sqvu_ram, sqvu_step.
`default_nettype none
module sqvu_back import sqvu_pkg::*; #(
  parameter int VECTOR_LENGTH = VECTOR_LENGTH_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               q_valid,
  input  wire item_t              q_item,
  output logic                    q_pop,
  input  wire logic [CFG_W-1:0]   alpha,
  input  wire logic [CFG_W-1:0]   maxit,
  output logic                    m_tvalid,
  input  wire logic               m_tready,
  output logic [TDATA_W-1:0]      m_tdata
);
  localparam int DEPTH = (VECTOR_LENGTH < (1 << IDX_W)) ? VECTOR_LENGTH : (1 << IDX_W);
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  typedef enum logic [1:0] {B_IDLE, B_MUL, B_WR, B_STEP} state_t;

  state_t                   state;
  item_t                    cur;
  logic [CNT_W-1:0]         count;
  logic [STEP_W-1:0]        cur_step;
  logic signed [SMP_W-1:0]  old;
  logic                     down;
  logic [40:0]              prod;
  logic [SMP_W-1:0]         rdata;
  logic                     we;
  logic [AW-1:0]            addr;
  logic [16:0]              a_c;
  logic                     ge_c;
  logic [17:0]              delta;
  logic signed [SMP_W+1:0]  sum;
  logic signed [SMP_W-1:0]  newv;
  logic [CNT_W-1:0]         cnt_next;
  step_req_t                sreq;
  step_rsp_t                srsp;
  logic                     out_free;

  assign out_free = !m_tvalid || m_tready;
  assign q_pop = (state == B_IDLE) && q_valid;
  assign addr = (state == B_IDLE) ? AW'(q_item.idx) : AW'(cur.idx);
  assign we = (state == B_WR) && out_free && cur.in_range;

  always_comb begin
    ge_c = ($signed(rdata) >= cur.sample);
    a_c = ge_c ? (17'h10000 - 17'(alpha)) : 17'(alpha);
    delta = 18'((prod + 41'h800000) >> 24);
    sum = down ? (34'(old) - 34'(delta)) : (34'(old) + 34'(delta));
    if (!cur.in_range) begin
      newv = '0;
    end else if (count == '0) begin
      newv = cur.sample;
    end else if (sum > 34'sh7FFFFFFF) begin
      newv = 32'sh7FFFFFFF;
    end else if (sum < -34'sh80000000) begin
      newv = 32'sh80000000;
    end else begin
      newv = sum[SMP_W-1:0];
    end
    cnt_next = (count == COUNT_MAX) ? COUNT_MAX : count + 16'd1;
    sreq.start = (state == B_WR) && out_free && cur.last;
    sreq.n = (cnt_next == COUNT_MAX) ? COUNT_MAX : cnt_next + 16'd1;
    sreq.nmax = maxit;
  end

  sqvu_ram #(.W(SMP_W), .D(DEPTH)) u_ram (
    .clk(clk), .we(we), .addr(addr), .wdata(newv), .rdata(rdata)
  );

  sqvu_step u_step (.clk(clk), .rst(rst), .req(sreq), .rsp(srsp));

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= B_IDLE;
      count <= '0;
      cur_step <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if ((state == B_WR) && out_free) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        B_IDLE: begin
          if (q_valid) begin
            cur <= q_item;
            state <= B_MUL;
          end
        end
        B_MUL: begin
          old <= $signed(rdata);
          down <= ge_c;
          prod <= 41'(a_c) * 41'(cur_step);
          state <= B_WR;
        end
        B_WR: begin
          if (out_free) begin
            m_tdata <= TDATA_W'({cur.idx, newv});
            if (cur.last) begin
              count <= cnt_next;
              state <= B_STEP;
            end else begin
              state <= B_IDLE;
            end
          end
        end
        B_STEP: begin
          if (srsp.done) begin
            cur_step <= srsp.step;
            state <= B_IDLE;
          end
        end
        default: state <= B_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

[hw/rtl/stochastic_quantile_vector_update_unit.sv]
// Top level: per-element running quantile estimator over a stream of vectors.
// m_tvalid rises as the back end writes the updated estimate back; the back end
// takes the next element only after that, and a stalled result beat holds it.
// A vector end also runs the step unit (long divider, 16 squarings, 16 root
// products) before the next element is taken.
// Reset (synchronous) clears control, counts and step and loads the config registers
// with their defaults; the estimate memory is not cleared and is written by the first vector.
`default_nettype none
module stochastic_quantile_vector_update_unit import sqvu_pkg::*; #(
  parameter int VECTOR_LENGTH = VECTOR_LENGTH_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               s_tvalid,
  output logic                    s_tready,
  input  wire logic [TDATA_W-1:0] s_tdata,   // sample_value[31:0], element_index[41:32]
  input  wire logic               s_tlast,   // vector_end
  output logic                    m_tvalid,
  input  wire logic               m_tready,
  output logic [TDATA_W-1:0]      m_tdata,   // estimate_value[31:0], estimate_index[41:32]
  input  wire logic               cfg_we,
  input  wire logic [0:0]         cfg_index,
  input  wire logic [CFG_W-1:0]   cfg_data
);
  logic [CFG_W-1:0] alpha;
  logic [CFG_W-1:0] maxit;
  logic             q_valid;
  item_t            q_item;
  logic             q_pop;

  always_ff @(posedge clk) begin
    if (rst) begin
      alpha <= ALPHA_RST;
      maxit <= MAXIT_RST;
    end else if (cfg_we) begin
      unique case (reg_idx_t'(cfg_index))
        REG_ALPHA: alpha <= cfg_data;
        REG_MAXIT: maxit <= cfg_data;
        default: ;
      endcase
    end
  end

  sqvu_front #(.VECTOR_LENGTH(VECTOR_LENGTH)) u_front (
    .clk(clk), .rst(rst), .s_tvalid(s_tvalid), .s_tready(s_tready),
    .s_tdata(s_tdata), .s_tlast(s_tlast),
    .q_valid(q_valid), .q_item(q_item), .q_pop(q_pop)
  );

  sqvu_back #(.VECTOR_LENGTH(VECTOR_LENGTH)) u_back (
    .clk(clk), .rst(rst), .q_valid(q_valid), .q_item(q_item), .q_pop(q_pop),
    .alpha(alpha), .maxit(maxit),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
  );
endmodule
`default_nettype wire

[hw/rtl/sqvu_checker.sv]
// Port-level checks for the quantile update unit, bound to the top level.
// Depends on sqvu_pkg.
`default_nettype none
module sqvu_checker import sqvu_pkg::*; (
  input wire logic               clk,
  input wire logic               rst,
  input wire logic               m_tvalid,
  input wire logic               m_tready,
  input wire logic [TDATA_W-1:0] m_tdata
);
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result beat dropped or changed while stalled");

  a_rst: assert property (@(posedge clk) $past(rst) |-> !m_tvalid)
    else $error("result beat right after reset");

  a_pad: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[TDATA_W-1:SMP_W+IDX_W] == '0)
    else $error("padding bits set in result beat");
endmodule

bind stochastic_quantile_vector_update_unit sqvu_checker u_chk (.*);
`default_nettype wire

[sim/tb_stochastic_quantile_vector_update_unit.sv]
// Testbench for stochastic_quantile_vector_update_unit: streams sample vectors,
// predicts each running quantile estimate and checks every result beat.
// Depends on sqvu_pkg and the top-level RTL.
`timescale 1ns / 1ps

module tb_stochastic_quantile_vector_update_unit;
  import sqvu_pkg::*;

  typedef struct {
    logic [31:0] sample;
    logic [9:0]  idx;
    logic        last;
  } elem_t;

  typedef struct {
    logic [31:0] est;
    logic [9:0]  idx;
  } est_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               s_tvalid = 1'b0;
  logic               s_tready;
  logic [TDATA_W-1:0] s_tdata = '0;
  logic               s_tlast = 1'b0;
  logic               m_tvalid;
  logic               m_tready = 1'b0;
  logic [TDATA_W-1:0] m_tdata;
  logic               cfg_we = 1'b0;
  logic [0:0]         cfg_index = REG_ALPHA;
  logic [CFG_W-1:0]   cfg_data = '0;

  elem_t pending_elems[$];
  est_t  expected_ests[$];
  elem_t cur_elem;
  int    written_idx[$];
  int    errors = 0;
  int    in_gap = 0;
  int    out_gap = 0;
  bit    quiet = 1'b0;

  // predictor state
  logic [31:0]     est_mem [1024];
  int unsigned     seen_vectors = 0;
  logic [23:0]     cur_step = '0;
  int unsigned     alpha_q16 = 32768;
  int unsigned     planned_vecs = 1000;
  longint unsigned root_q30 [16];

  stochastic_quantile_vector_update_unit u_dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #10 clk = ~clk;

  function automatic longint unsigned floor_root(longint unsigned v);
    longint unsigned res, b;
    res = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v = v - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  function automatic int unsigned log2_q16(int unsigned n);
    int unsigned     e, frac;
    longint unsigned x;
    e = 0;
    frac = 0;
    if (n == 0) return 0;
    while (e < 31 && (n >> (e + 1)) != 0) e++;
    x = (longint'(n) << 30) >> e;
    for (int i = 0; i < 16; i++) begin
      x = (x * x) >> 30;
      frac = frac << 1;
      if (x >= (64'd2 << 30)) begin
        x = x >> 1;
        frac = frac | 1;
      end
    end
    return (e << 16) | frac;
  endfunction

  function automatic logic [23:0] decay_step(int unsigned n, int unsigned nmax);
    longint unsigned d, g, e, r, s;
    int unsigned     k, f;
    if (nmax < 2) nmax = 2;
    d = nmax - 1;
    g = 6554 + (64'd58982 * longint'(n - 1) + d / 2) / d;
    e = (g * longint'(log2_q16(n)) + 32768) >> 16;
    if ((e >> 16) > 24) return '0;
    k = 32'(e >> 16);
    f = 32'(e & 64'hFFFF);
    r = 64'd1 << 30;
    for (int j = 1; j <= 16; j++)
      if ((f >> (16 - j)) & 1) r = (r * root_q30[j-1]) >> 30;
    s = (r + (64'd1 << (5 + k))) >> (6 + k);
    if (s > 64'hFFFFFF) s = 64'hFFFFFF;
    return s[23:0];
  endfunction

  task automatic predict_estimate(input elem_t it);
    longint smp, est, delta;
    int unsigned n;
    est_t r;
    smp = longint'($signed(it.sample));
    if (seen_vectors == 0) begin
      est = smp;
    end else begin
      est = longint'($signed(est_mem[it.idx]));
      if (est >= smp) begin
        delta = ((65536 - alpha_q16) * longint'(cur_step) + (64'd1 << 23)) >> 24;
        est = est - delta;
      end else begin
        delta = (alpha_q16 * longint'(cur_step) + (64'd1 << 23)) >> 24;
        est = est + delta;
      end
      if (est > 64'sd2147483647) est = 64'sd2147483647;
      if (est < -64'sd2147483648) est = -64'sd2147483648;
    end
    est_mem[it.idx] = est[31:0];
    r.est = est[31:0];
    r.idx = it.idx;
    expected_ests.push_back(r);
    if (it.last) begin
      if (seen_vectors < 65535) seen_vectors++;
      n = (seen_vectors + 1 > 65535) ? 65535 : seen_vectors + 1;
      cur_step = decay_step(n, planned_vecs);
    end
  endtask

  // driver
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
      in_gap = 0;
    end else begin
      if (s_tvalid && s_tready) predict_estimate(cur_elem);
      if (!s_tvalid || s_tready) begin
        if (in_gap > 0) begin
          in_gap--;
          s_tvalid <= 1'b0;
        end else if (pending_elems.size() > 0) begin
          if (!quiet && $urandom_range(0, 7) == 0) begin
            in_gap = $urandom_range(1, 18) - 1;
            s_tvalid <= 1'b0;
          end else begin
            cur_elem = pending_elems.pop_front();
            s_tvalid <= 1'b1;
            s_tdata <= {6'd0, cur_elem.idx, cur_elem.sample};
            s_tlast <= cur_elem.last;
          end
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
      out_gap = 0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (expected_ests.size() == 0) begin
          $error("unexpected result beat: estimate_value %h estimate_index %0d",
                 m_tdata[31:0], m_tdata[41:32]);
          errors++;
        end else begin
          est_t e;
          e = expected_ests.pop_front();
          if (m_tdata[31:0] !== e.est) begin
            $error("estimate_value: expected %h actual %h", e.est, m_tdata[31:0]);
            errors++;
          end
          if (m_tdata[41:32] !== e.idx) begin
            $error("estimate_index: expected %0d actual %0d", e.idx, m_tdata[41:32]);
            errors++;
          end
        end
      end
      if (out_gap > 0) begin
        out_gap--;
        m_tready <= 1'b0;
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
        out_gap = $urandom_range(1, 18) - 1;
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  task automatic add_elem(input logic [31:0] smp, input int idx, input bit last);
    elem_t it;
    it.sample = smp;
    it.idx = idx[9:0];
    it.last = last;
    pending_elems.push_back(it);
  endtask

  task automatic add_vector(input int len);
    logic [31:0] smp;
    for (int i = 0; i < len; i++) begin
      case ($urandom_range(0, 3))
        0: smp = $urandom_range(0, 8) << 16;
        1: smp = -($urandom_range(0, 8) << 16);
        default: smp = $urandom;
      endcase
      add_elem(smp, written_idx[$urandom_range(0, written_idx.size() - 1)], i == len - 1);
    end
  endtask

  task automatic drain();
    while (pending_elems.size() != 0 || s_tvalid || expected_ests.size() != 0)
      @(posedge clk);
    repeat (120) @(posedge clk);
  endtask

  task automatic write_regs(input int unsigned a, input int unsigned m);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= REG_ALPHA;
    cfg_data <= a[15:0];
    @(posedge clk);
    cfg_index <= REG_MAXIT;
    cfg_data <= m[15:0];
    @(posedge clk);
    cfg_we <= 1'b0;
    alpha_q16 = a;
    planned_vecs = m;
  endtask

  task automatic random_phase(input int count);
    int len;
    while (count > 0) begin
      len = $urandom_range(1, 14);
      add_vector(len);
      count -= len;
    end
  endtask

  initial begin
    logic [63:0] c;
    c = floor_root(64'd1 << 59);
    for (int j = 0; j < 16; j++) begin
      root_q30[j] = c;
      c = floor_root(c << 30);
    end
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // first vector writes entries 0..19 and 1023; extremes set up saturation
    add_elem(32'h0000_0000, 0, 0);
    add_elem(32'hFFFF_FFFF, 1, 0);
    add_elem(32'h7FFF_FFF0, 2, 0);
    add_elem(32'h8000_0005, 3, 0);
    add_elem(32'h7FFF_FFFF, 4, 0);
    add_elem(32'h8000_0000, 5, 0);
    for (int i = 6; i < 20; i++) add_elem($urandom, i, 0);
    add_elem(32'h5555_AAAA, 1023, 1);
    for (int i = 0; i < 20; i++) written_idx.push_back(i);
    written_idx.push_back(1023);
    // saturation up and down, equal compare
    add_elem(32'h7FFF_FFFF, 2, 0);
    add_elem(32'h8000_0000, 3, 0);
    add_elem(32'h7FFF_FFFF, 4, 0);
    add_elem(32'h8000_0000, 5, 1);
    drain();

    write_regs(0, 2);
    random_phase(150);
    drain();
    write_regs(65535, 65535);
    random_phase(150);
    drain();
    write_regs(1, 1);
    random_phase(120);
    drain();
    write_regs($urandom_range(0, 65535), $urandom_range(2, 300));
    random_phase(150);
    drain();
    write_regs(32768, 1000);
    quiet = 1'b1;
    random_phase(150);
    drain();

    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("Verification failed");
    $finish;
  end

endmodule

[sim.f]
hw/rtl/sqvu_pkg.sv
hw/rtl/sqvu_ram.sv
hw/rtl/sqvu_front.sv
hw/rtl/sqvu_step.sv
hw/rtl/sqvu_back.sv
hw/rtl/stochastic_quantile_vector_update_unit.sv
hw/rtl/sqvu_checker.sv
sim/tb_stochastic_quantile_vector_update_unit.sv
